FILE: hdl/itrd_pkg.sv
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared types, widths and helpers for the integer to radix digit converter.
// ----------------------------------------------------------------------------
package itrd_pkg;

  localparam int VALUE_W           = 64;
  localparam int RADIX_W           = 6;
  localparam int CHAR_W            = 7;
  localparam int DIGIT_W           = 6;
  localparam int REM_W             = DIGIT_W + 1;
  localparam int DIGIT_STORE_DEPTH = 64;
  localparam int IDX_W             = $clog2(DIGIT_STORE_DEPTH);
  localparam int CNT_W             = $clog2(DIGIT_STORE_DEPTH + 1);
  localparam int BIT_W             = $clog2(VALUE_W);
  localparam int RADIX_MIN         = 2;
  localparam int RADIX_MAX         = 36;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_EMIT,
    ST_ERR
  } itrd_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
    logic err;
  } itrd_cmd_t;

  typedef struct packed {
    logic radix_bad;
    logic last_step;
    logic done;
    logic rd_last;
    logic out_free;
  } itrd_sts_t;

  // digit value to ASCII: '0'-'9' then 'A'-'Z'
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] base;
    base = (d < DIGIT_W'(10)) ? CHAR_W'(48) : CHAR_W'(55);
    return base + CHAR_W'(d);
  endfunction

endpackage

FILE: hdl/itrd_if.sv
// ----------------------------------------------------------------------------
// itrd_if
// Valid/ready channel interfaces for input items and digit results.
// ----------------------------------------------------------------------------
interface itrd_in_if
  import itrd_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic        [RADIX_W-1:0] radix;

  modport source (output valid, value, radix, input ready);
  modport sink   (input valid, value, radix, output ready);
endinterface

interface itrd_out_if
  import itrd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              negative;
  logic              last;
  logic              bad_radix;

  modport source (output valid, character, negative, last, bad_radix, input ready);
  modport sink   (input valid, character, negative, last, bad_radix, output ready);
endinterface

FILE: hdl/itrd_ram.sv
// ----------------------------------------------------------------------------
// itrd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module itrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/itrd_ctrl.sv
// ----------------------------------------------------------------------------
// itrd_ctrl
// Sequencer: accept, divide per digit, then read back and emit digits.
// ----------------------------------------------------------------------------
module itrd_ctrl
  import itrd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  itrd_sts_t sts,
  output itrd_cmd_t cmd
);

  itrd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (sts.radix_bad) begin
            state_nxt = ST_ERR;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.last_step && sts.done) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.rd_last ? ST_IDLE : ST_READ;
        end
      end
      ST_ERR: begin
        if (sts.out_free) begin
          cmd.err   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/itrd_dp.sv
// ----------------------------------------------------------------------------
// itrd_dp
// Datapath: bit-serial restoring divider, digit store and result register.
// ----------------------------------------------------------------------------
module itrd_dp
  import itrd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  itrd_cmd_t          cmd,
  output itrd_sts_t          sts,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [RADIX_W-1:0] in_radix,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAR_W-1:0]  out_character,
  output logic               out_negative,
  output logic               out_last,
  output logic               out_bad_radix
);

  logic [VALUE_W-1:0] quo_r;
  logic [REM_W-1:0]   rem_r;
  logic [RADIX_W-1:0] radix_r;
  logic               neg_r;
  logic [BIT_W-1:0]   bitcnt_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [IDX_W-1:0]   rd_idx_r;

  logic               out_valid_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic               out_neg_r;
  logic               out_last_r;
  logic               out_bad_r;

  logic [REM_W-1:0]   rem_sh;
  logic [REM_W-1:0]   rad_ext;
  logic               ge;
  logic [REM_W-1:0]   rem_new;
  logic [VALUE_W-1:0] quo_new;
  logic [VALUE_W-1:0] mag;
  logic               last_step;
  logic               store_en;
  logic [DIGIT_W-1:0] rd_digit;
  logic               out_free;

  // one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_r[REM_W-2:0], quo_r[VALUE_W-1]};
    rad_ext = {1'b0, radix_r};
    ge      = (rem_sh >= rad_ext);
    rem_new = ge ? (rem_sh - rad_ext) : rem_sh;
    quo_new = {quo_r[VALUE_W-2:0], ge};
    mag     = in_value[VALUE_W-1] ? (VALUE_W'(0) - in_value) : in_value;
  end

  assign last_step = (bitcnt_r == BIT_W'(VALUE_W - 1));
  assign store_en  = cmd.step && last_step;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    sts.radix_bad = (in_radix < RADIX_W'(RADIX_MIN)) || (in_radix > RADIX_W'(RADIX_MAX));
    sts.last_step = last_step;
    sts.done      = (quo_new == '0) || (cnt_r == CNT_W'(DIGIT_STORE_DEPTH - 1));
    sts.rd_last   = (rd_idx_r == '0);
    sts.out_free  = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_r    <= mag;
      rem_r    <= '0;
      radix_r  <= in_radix;
      neg_r    <= in_value[VALUE_W-1];
      bitcnt_r <= '0;
      cnt_r    <= '0;
    end else if (cmd.step) begin
      quo_r    <= quo_new;
      rem_r    <= last_step ? '0 : rem_new;
      bitcnt_r <= bitcnt_r + BIT_W'(1);
      if (last_step) begin
        cnt_r    <= cnt_r + CNT_W'(1);
        rd_idx_r <= cnt_r[IDX_W-1:0];
      end
    end else if (cmd.emit) begin
      rd_idx_r <= rd_idx_r - IDX_W'(1);
    end
  end

  itrd_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (DIGIT_STORE_DEPTH)
  ) u_digit_store (
    .clk     (clk),
    .wr_en   (store_en),
    .wr_addr (cnt_r[IDX_W-1:0]),
    .wr_data (rem_new[DIGIT_W-1:0]),
    .rd_addr (rd_idx_r),
    .rd_data (rd_digit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.err) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char_r <= digit_char(rd_digit);
      out_neg_r  <= neg_r;
      out_last_r <= (rd_idx_r == '0);
      out_bad_r  <= 1'b0;
    end else if (cmd.err) begin
      out_char_r <= '0;
      out_neg_r  <= 1'b0;
      out_last_r <= 1'b1;
      out_bad_r  <= 1'b1;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_negative  = out_neg_r;
  assign out_last      = out_last_r;
  assign out_bad_radix = out_bad_r;

endmodule

FILE: hdl/integer_to_radix_digits.sv
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Converts a signed 64-bit value to ASCII digits in radix 2..36, MSD first.
// ----------------------------------------------------------------------------
// One item is worked at a time. After acceptance each digit is produced by
// the shared bit-serial restoring divider (one quotient bit per cycle); the
// digit store is then read back and each digit loaded into the result
// register. A bad radix gives one error transaction instead. A stalled
// result holds the emit sequence; a new item is taken once the last result
// is registered.
module integer_to_radix_digits
  import itrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  itrd_in_if.sink    in_ch,
  itrd_out_if.source out_ch
);

  itrd_cmd_t cmd;
  itrd_sts_t sts;

  itrd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  itrd_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_value      (in_ch.value),
    .in_radix      (in_ch.radix),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_character (out_ch.character),
    .out_negative  (out_ch.negative),
    .out_last      (out_ch.last),
    .out_bad_radix (out_ch.bad_radix)
  );

endmodule

FILE: test/integer_to_radix_digits_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_to_radix_digits_tb
// Self-checking bench for the radix digit converter. Directed corner values
// and radices are followed by random values of mixed size, sent under random
// source and sink idling. Every digit transaction is checked against a
// behavioral conversion computed when its input is accepted.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_tb;
  import itrd_pkg::*;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic        [RADIX_W-1:0] radix;
  } conv_item_t;

  typedef struct {
    logic [CHAR_W-1:0] character;
    logic              negative;
    logic              last;
    logic              bad_radix;
  } digit_result_t;

  localparam int    RANDOM_ITEMS = 118;
  localparam int    DRAIN_CYCLES = 4300;
  localparam string DIGIT_SET    = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
  localparam logic [VALUE_W-1:0] INT64_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] INT64_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  itrd_in_if  in_ch ();
  itrd_out_if out_ch ();

  integer_to_radix_digits i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  conv_item_t    conv_queue[$];
  digit_result_t digit_queue[$];
  int            total_items;
  int            items_presented;
  int            items_accepted;
  int            mismatch_count;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // converts one value, MSD first, onto the expected digit queue
  task automatic predict_digits(input logic [VALUE_W-1:0] raw, input logic [RADIX_W-1:0] radix);
    logic [VALUE_W-1:0] magnitude;
    logic [DIGIT_W-1:0] digits[DIGIT_STORE_DEPTH];
    digit_result_t      res;
    int                 n;
    if (radix < RADIX_MIN || radix > RADIX_MAX) begin
      res.character = '0;
      res.negative  = 1'b0;
      res.last      = 1'b1;
      res.bad_radix = 1'b1;
      digit_queue.push_back(res);
      return;
    end
    magnitude = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
    n = 0;
    do begin
      digits[n] = DIGIT_W'(magnitude % VALUE_W'(radix));
      n++;
      magnitude = magnitude / VALUE_W'(radix);
    end while (magnitude != 0 && n < DIGIT_STORE_DEPTH);
    for (int k = n - 1; k >= 0; k--) begin
      res.character = CHAR_W'(DIGIT_SET[digits[k]]);
      res.negative  = raw[VALUE_W-1];
      res.last      = (k == 0);
      res.bad_radix = 1'b0;
      digit_queue.push_back(res);
    end
  endtask

  function automatic int sender_idle_pct();
    if (items_accepted < total_items / 3) return 29;
    if (items_accepted < 2 * total_items / 3) return 51;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (items_accepted < total_items / 3) return 51;
    if (items_accepted < 2 * total_items / 3) return 29;
    return 0;
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] v;
    int                 w;
    v = {$urandom, $urandom};
    w = ($urandom_range(9) < 3) ? VALUE_W : $urandom_range(1, 24);
    if (w < VALUE_W) v = v & ((VALUE_W'(1) << w) - 1'b1);
    if ($urandom_range(1) == 1) v = ~v + 1'b1;
    return v;
  endfunction

  function automatic logic [RADIX_W-1:0] rand_radix();
    if ($urandom_range(99) < 12) begin
      if ($urandom_range(1) == 1) return RADIX_W'($urandom_range(1));
      return RADIX_W'($urandom_range(RADIX_MAX + 1, 2**RADIX_W - 1));
    end
    return RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
  endfunction

  task automatic add_item(input longint value, input int radix);
    conv_item_t item;
    item.value = value;
    item.radix = RADIX_W'(radix);
    conv_queue.push_back(item);
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && items_accepted < items_presented)) begin
      if (conv_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
        in_ch.valid <= 1'b1;
        in_ch.value <= conv_queue[0].value;
        in_ch.radix <= conv_queue[0].radix;
        conv_queue.pop_front();
        items_presented++;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result sink backpressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  // monitor
  always @(posedge clk) begin
    digit_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        predict_digits(in_ch.value, in_ch.radix);
        items_accepted++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (digit_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction, character %0d", out_ch.character));
        end else begin
          want = digit_queue.pop_front();
          if (out_ch.character !== want.character)
            report_mismatch($sformatf("character got %0d want %0d",
                                      out_ch.character, want.character));
          if (out_ch.negative !== want.negative)
            report_mismatch($sformatf("negative got %b want %b",
                                      out_ch.negative, want.negative));
          if (out_ch.last !== want.last)
            report_mismatch($sformatf("last got %b want %b", out_ch.last, want.last));
          if (out_ch.bad_radix !== want.bad_radix)
            report_mismatch($sformatf("bad_radix got %b want %b",
                                      out_ch.bad_radix, want.bad_radix));
        end
      end
    end
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    in_ch.radix  = '0;
    out_ch.ready = 1'b0;

    add_item('0, 10);
    add_item('0, RADIX_MIN);
    add_item('0, RADIX_MAX);
    add_item(1, RADIX_MIN);
    add_item(-1, 10);
    add_item(INT64_MIN, RADIX_MIN);
    add_item(INT64_MIN, 10);
    add_item(INT64_MIN, RADIX_MAX);
    add_item(INT64_MAX, RADIX_MIN);
    add_item(INT64_MAX, 16);
    add_item(INT64_MAX, RADIX_MAX);
    add_item(35, RADIX_MAX);
    add_item(36, RADIX_MAX);
    add_item(-35, RADIX_MAX);
    add_item(-12345, 10);
    add_item(255, 8);
    add_item(1000, 3);
    add_item(-64'sd823543, 7);
    add_item(42, 0);
    add_item(-7, 1);
    add_item(INT64_MIN, RADIX_MAX + 1);
    add_item(INT64_MAX, 2**RADIX_W - 1);
    for (int i = 0; i < RANDOM_ITEMS; i++) add_item(rand_value(), rand_radix());
    total_items = conv_queue.size();

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    while (items_accepted < total_items || digit_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("integer_to_radix_digits regression: pass");
    end else begin
      $display("integer_to_radix_digits regression: fail");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("%0t ns: timeout", $time);
    $display("integer_to_radix_digits regression: fail");
    $finish;
  end

endmodule
